@@ hdl/npe_pkg.sv @@
// Package for the next-permutation engine: beat types and default sizing.
// Used by npe_cmp, the top level and its checker.
`default_nettype none

package npe_pkg;

	localparam int unsigned MAX_LEN_DEF = 16;
	localparam int unsigned DATA_W      = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] element_value;
		logic                     is_last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic                     out_last;
		logic                     wrapped;
		logic                     overflowed;
	} result_t;

endpackage : npe_pkg

`default_nettype wire

@@ hdl/npe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module npe_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : npe_ram

`default_nettype wire

@@ hdl/npe_cmp.sv @@
// Shared signed less-than unit used by the pivot and successor scans.
// Depends on npe_pkg for the data width.
`default_nettype none

module npe_cmp (
	input  wire logic signed [npe_pkg::DATA_W-1:0] a,
	input  wire logic signed [npe_pkg::DATA_W-1:0] b,
	output      logic                              lt
);

	import npe_pkg::*;

	assign lt = (a < b);

endmodule : npe_cmp

`default_nettype wire

@@ hdl/next_permutation_engine_top.sv @@
// Next lexicographic permutation engine: sequencer, sequence RAM, shared compare.
// Depends on npe_pkg, npe_ram and npe_cmp.
//
// Usage:
//   The item channel takes one element per beat; the beat with is_last set
//   closes the sequence. Elements past MAX_LEN are dropped and flagged on
//   every result beat through overflowed. While loading, one beat is taken
//   per cycle.
//   After the last beat item_stall rises and the sequencer scans the RAM from
//   the right for the pivot, then, if a pivot is found, for the rightmost
//   larger element, then emits n result beats for the n stored elements.
//   The tail is reversed by address mapping on the way out, so the RAM is
//   only ever written while loading.
//   result_stall holds the current result beat in its output register and
//   pauses the sequencer. Reset clears the counters and returns the block to
//   loading; RAM contents are not cleared and only entries of the current
//   sequence are ever read.
`default_nettype none

module next_permutation_engine_top #(
	parameter int unsigned MAX_LEN = npe_pkg::MAX_LEN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output      logic             item_stall,
	input  wire npe_pkg::item_t   item,
	output      logic             result_valid,
	input  wire logic             result_stall,
	output      npe_pkg::result_t result
);

	import npe_pkg::*;

	localparam int unsigned IW = $clog2(MAX_LEN);
	localparam int unsigned CW = $clog2(MAX_LEN + 1);
	localparam int unsigned SW = CW + 1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_P_RD,
		ST_P_CHK,
		ST_Q_RD,
		ST_Q_CHK,
		ST_O_RD,
		ST_O_CAP,
		ST_O_OUT
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            cnt_q;
	logic                     ovf_q;
	logic [CW-1:0]            n_q;
	logic [IW-1:0]            idx_q;
	logic                     first_q;
	logic signed [DATA_W-1:0] prev_q;
	logic signed [DATA_W-1:0] piv_q;
	logic signed [DATA_W-1:0] qval_q;
	logic [IW-1:0]            p_q;
	logic [IW-1:0]            q_q;
	logic                     wrap_q;
	logic [IW-1:0]            k_q;
	result_t                  result_q;
	logic                     result_valid_q;

	logic                     item_acc;
	logic                     room;
	logic [CW-1:0]            n_load;
	logic                     ram_re;
	logic [IW-1:0]            ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic signed [DATA_W-1:0] rd_val;
	logic signed [DATA_W-1:0] cmp_a;
	logic signed [DATA_W-1:0] cmp_b;
	logic                     cmp_lt;
	logic [SW-1:0]            s_wide;
	logic [IW-1:0]            src_idx;
	logic [IW-1:0]            last_idx;
	logic signed [DATA_W-1:0] out_val;

	assign item_stall   = (state_q != ST_LOAD);
	assign item_acc     = item_valid && (state_q == ST_LOAD);
	assign room         = (cnt_q < CW'(MAX_LEN));
	assign n_load       = room ? (cnt_q + CW'(1)) : cnt_q;
	assign rd_val       = ram_rdata;
	assign last_idx     = IW'(n_q - CW'(1));
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Output index k maps to source n-1+p-k inside the reversed tail.
	assign s_wide  = SW'(n_q) + SW'(p_q) - SW'(k_q) - SW'(1);
	assign src_idx = (k_q >= p_q) ? IW'(s_wide) : k_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			ST_P_RD, ST_Q_RD: begin
				ram_re = 1'b1;
			end
			ST_O_RD: begin
				ram_re    = 1'b1;
				ram_raddr = src_idx;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmp_a = rd_val;
		cmp_b = prev_q;
		if (state_q == ST_Q_CHK) begin
			cmp_a = piv_q;
			cmp_b = rd_val;
		end
	end

	// Swap falls out of the mapping: pivot slot takes the successor, the
	// successor slot in the tail takes the pivot.
	always_comb begin
		out_val = rd_val;
		if (p_q != '0 && (k_q + IW'(1)) == p_q) begin
			out_val = qval_q;
		end else if (p_q != '0 && k_q >= p_q && src_idx == q_q) begin
			out_val = piv_q;
		end
	end

	npe_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_LEN)
	) u_ram (
		.clk  (clk),
		.we   (item_acc && room),
		.waddr(cnt_q[IW-1:0]),
		.wdata(item.element_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	npe_cmp u_cmp (
		.a (cmp_a),
		.b (cmp_b),
		.lt(cmp_lt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
			n_q            <= '0;
			idx_q          <= '0;
			first_q        <= 1'b0;
			prev_q         <= '0;
			piv_q          <= '0;
			qval_q         <= '0;
			p_q            <= '0;
			q_q            <= '0;
			wrap_q         <= 1'b0;
			k_q            <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (item_acc) begin
						cnt_q <= n_load;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (item.is_last) begin
							n_q     <= n_load;
							idx_q   <= IW'(n_load - CW'(1));
							first_q <= 1'b1;
							state_q <= ST_P_RD;
						end
					end
				end
				ST_P_RD: begin
					state_q <= ST_P_CHK;
				end
				ST_P_CHK: begin
					if (!first_q && cmp_lt) begin
						p_q     <= idx_q + IW'(1);
						piv_q   <= rd_val;
						idx_q   <= last_idx;
						state_q <= ST_Q_RD;
					end else begin
						first_q <= 1'b0;
						prev_q  <= rd_val;
						if (idx_q == '0) begin
							// no ascent: plain reversal, a lone element is not a wrap
							p_q     <= '0;
							wrap_q  <= (n_q != CW'(1));
							k_q     <= '0;
							state_q <= ST_O_RD;
						end else begin
							idx_q   <= idx_q - IW'(1);
							state_q <= ST_P_RD;
						end
					end
				end
				ST_Q_RD: begin
					state_q <= ST_Q_CHK;
				end
				ST_Q_CHK: begin
					if (cmp_lt) begin
						q_q     <= idx_q;
						qval_q  <= rd_val;
						wrap_q  <= 1'b0;
						k_q     <= '0;
						state_q <= ST_O_RD;
					end else begin
						idx_q   <= idx_q - IW'(1);
						state_q <= ST_Q_RD;
					end
				end
				ST_O_RD: begin
					state_q <= ST_O_CAP;
				end
				ST_O_CAP: begin
					result_q.out_value  <= out_val;
					result_q.out_last   <= (k_q == last_idx);
					result_q.wrapped    <= wrap_q;
					result_q.overflowed <= ovf_q;
					result_valid_q      <= 1'b1;
					state_q             <= ST_O_OUT;
				end
				ST_O_OUT: begin
					if (!result_stall) begin
						result_valid_q <= 1'b0;
						if (k_q == last_idx) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= ST_O_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule : next_permutation_engine_top

`default_nettype wire

@@ hdl/npe_chk.sv @@
// Port-level checker for the next-permutation engine, bound to the top level.
// Depends on npe_pkg for the beat types.
`default_nettype none

module npe_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire npe_pkg::item_t   item,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire npe_pkg::result_t result
);

	import npe_pkg::*;

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// no item is taken while results are being emitted
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item channel open while a result is pending");

	// closing beat of a sequence starts the busy phase
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.is_last |=> item_stall)
		else $error("item channel open right after the last beat");

	// final result ends the run and reopens loading
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.out_last |=> !result_valid && !item_stall)
		else $error("run did not end after final result beat");

endmodule : npe_chk

bind next_permutation_engine_top npe_chk u_npe_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item        (item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

`default_nettype wire

@@ tb/perm_check_pkg.sv @@
// Scoreboard for the next-permutation engine: predicts every result beat from the
// accepted element beats and checks the result beats against those predictions.
// Depends on npe_pkg.
package perm_check_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	import npe_pkg::*;

	localparam int unsigned SEQ_DEPTH = MAX_LEN_DEF;

	class perm_checker;
		logic signed [DATA_W-1:0] seq_buf [SEQ_DEPTH];
		int unsigned seq_len;
		bit          dropped;
		result_t     pending_perm_beats[$];
		int unsigned mismatches;

		// Store one element beat; on the closing beat form the next permutation
		// and queue one result beat per stored element.
		function void take_element(item_t it);
			int  p;
			int  q;
			int  lo;
			int  hi;
			bit  wrap;
			logic signed [DATA_W-1:0] tmp;
			result_t beat;
			if (seq_len < SEQ_DEPTH) begin
				seq_buf[seq_len] = it.element_value;
				seq_len++;
			end else begin
				dropped = 1'b1;
			end
			if (!it.is_last)
				return;
			wrap = 1'b0;
			if (seq_len >= 2) begin
				p = seq_len - 1;
				while (p > 0 && !(seq_buf[p-1] < seq_buf[p]))
					p--;
				if (p == 0) begin
					wrap = 1'b1;
					lo = 0;
				end else begin
					// swap pivot with the rightmost strictly larger element
					q = seq_len - 1;
					while (q > p && !(seq_buf[p-1] < seq_buf[q]))
						q--;
					tmp = seq_buf[p-1];
					seq_buf[p-1] = seq_buf[q];
					seq_buf[q] = tmp;
					lo = p;
				end
				hi = seq_len - 1;
				while (lo < hi) begin
					tmp = seq_buf[lo];
					seq_buf[lo] = seq_buf[hi];
					seq_buf[hi] = tmp;
					lo++;
					hi--;
				end
			end
			for (int k = 0; k < seq_len; k++) begin
				beat.out_value  = seq_buf[k];
				beat.out_last   = (k + 1 == seq_len);
				beat.wrapped    = wrap;
				beat.overflowed = dropped;
				pending_perm_beats.push_back(beat);
			end
			seq_len = 0;
			dropped = 1'b0;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_perm_beats.size() == 0) begin
				$display("%0t: result beat with none outstanding: expected none, got value %0d last %0b",
					$time, got.out_value, got.out_last);
				mismatches++;
				return;
			end
			want = pending_perm_beats.pop_front();
			if (got.out_value !== want.out_value) begin
				$display("%0t: out_value expected %0d got %0d", $time, want.out_value, got.out_value);
				mismatches++;
			end
			if (got.out_last !== want.out_last) begin
				$display("%0t: out_last expected %0b got %0b", $time, want.out_last, got.out_last);
				mismatches++;
			end
			if (got.wrapped !== want.wrapped) begin
				$display("%0t: wrapped expected %0b got %0b", $time, want.wrapped, got.wrapped);
				mismatches++;
			end
			if (got.overflowed !== want.overflowed) begin
				$display("%0t: overflowed expected %0b got %0b", $time, want.overflowed,
					got.overflowed);
				mismatches++;
			end
		endfunction
	endclass

endpackage : perm_check_pkg

@@ tb/tb_top.sv @@
// Top-level testbench for next_permutation_engine_top: directed sequences, then
// random ones under bursty sending and patterned result stalls.
// Depends on npe_pkg and perm_check_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import npe_pkg::*;
	import perm_check_pkg::*;

	localparam int unsigned ITEM_TARGET  = 400;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES = 7 * SEQ_DEPTH + 16;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
	typedef enum int {FILL_SMALL, FILL_FULL, FILL_DESCENDING, FILL_EXTREME, FILL_EQUAL} fill_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	perm_checker perm_sb = new;

	logic signed [DATA_W-1:0] seq_vals[$];
	int unsigned beats_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_hold  = 0;
	int unsigned cycle_cnt   = 0;
	stall_mode_t stall_mode  = STALL_NONE;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	next_permutation_engine_top #(
		.MAX_LEN(SEQ_DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// Present one element beat and hold it until taken; gap between bursts.
	task automatic drive_beat(input logic signed [DATA_W-1:0] v, input logic last);
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		item_valid <= 1'b1;
		item <= '{element_value: v, is_last: last};
		@(posedge clk);
		while (item_stall) @(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	task automatic send_seq();
		for (int k = 0; k < seq_vals.size(); k++)
			drive_beat(seq_vals[k], k == seq_vals.size() - 1);
	endtask

	task automatic send_random_seq();
		int unsigned len;
		int unsigned pick;
		fill_t fill;
		logic signed [DATA_W-1:0] v;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			len = $urandom_range(1, 8);
		else if (pick < 18)
			len = $urandom_range(9, SEQ_DEPTH);
		else
			len = $urandom_range(SEQ_DEPTH + 1, SEQ_DEPTH + 4);
		fill = fill_t'($urandom_range(0, 4));
		v = $urandom_range(0, 100000);
		seq_vals.delete();
		for (int k = 0; k < len; k++) begin
			case (fill)
				FILL_SMALL:      v = $urandom_range(0, 6) - 3;
				FILL_FULL:       v = $urandom;
				FILL_DESCENDING: v = v - $urandom_range(0, 2);
				FILL_EXTREME: begin
					case ($urandom_range(0, 4))
						0:       v = VAL_MIN;
						1:       v = VAL_MAX;
						2:       v = -1;
						3:       v = 0;
						default: v = 1;
					endcase
				end
				FILL_EQUAL: begin
					if (k == 0)
						v = $urandom;
				end
				default: v = $urandom;
			endcase
			seq_vals.push_back(v);
		end
		send_seq();
	endtask

	// Sample both channels, then pick the next receiver stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				perm_sb.take_element(item);
			if (result_valid && !result_stall)
				perm_sb.check_result(result);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			cycle_cnt <= cycle_cnt + 1;
			if (stall_hold == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_hold <= $urandom_range(20, 150);
			end else begin
				stall_hold <= stall_hold - 1;
			end
			case (stall_mode)
				STALL_NONE:     result_stall <= 1'b0;
				STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: result_stall <= cycle_cnt[2];
				default:        result_stall <= 1'b0;
			endcase
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// single element, returned unchanged
		seq_vals = '{VAL_MIN};
		send_seq();
		seq_vals = '{1, 2, 3};
		send_seq();
		// greatest permutation wraps to ascending
		seq_vals = '{3, 2, 1};
		send_seq();
		seq_vals = '{VAL_MIN, VAL_MAX};
		send_seq();
		seq_vals = '{VAL_MAX, -1, 0, VAL_MIN};
		send_seq();
		// equal elements: no strict ascent
		seq_vals = '{7, 7, 7};
		send_seq();
		seq_vals = '{1, 3, 3, 2};
		send_seq();

		while (beats_sent < ITEM_TARGET)
			send_random_seq();
		item_valid <= 1'b0;

		// let the sampler log the closing beat before looking at the queue
		@(posedge clk);
		while (perm_sb.pending_perm_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (perm_sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule : tb_top
